// ===== hw/rtl/azimuthal_radial_averager_macros.svh =====
// Assertion macros shared by the averager RTL.
`ifndef AZIMUTHAL_RADIAL_AVERAGER_MACROS_SVH
`define AZIMUTHAL_RADIAL_AVERAGER_MACROS_SVH

// Condition and consequence in the same cycle.
`define ARA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("averager check failed");

// Consequence in the cycle after the condition.
`define ARA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("averager check failed");

`endif

// ===== hw/rtl/ara_pkg.sv =====
// Types and constants of the azimuthal radial averager.
`default_nettype none
package ara_pkg;

    localparam int SUM_W   = 48;
    localparam int RAD_W   = 20;
    localparam int NCNT_W  = 5;
    localparam int SCALE_W = 16;
    localparam int PIX_W   = 32;
    localparam int CNT_W   = 6;
    localparam int TWO_PI_W = 19;

    localparam logic [TWO_PI_W-1:0] TWO_PI_Q16 = 19'd411775;
    localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

    localparam logic [RAD_W-1:0]   INNER_RST = 20'd45875;
    localparam logic [RAD_W-1:0]   OUTER_RST = 20'd255590;
    localparam logic [NCNT_W-1:0]  COUNT_RST = 5'd15;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd6554;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_INNER = 2'd0,
        REG_OUTER = 2'd1,
        REG_COUNT = 2'd2,
        REG_SCALE = 2'd3
    } t_reg_index;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_D2    = 15'b000000000000010,
        S_M1    = 15'b000000000000100,
        S_M2    = 15'b000000000001000,
        S_SQS   = 15'b000000000010000,
        S_SQRT  = 15'b000000000100000,
        S_RANGE = 15'b000000001000000,
        S_BIN   = 15'b000000010000000,
        S_RDMEM = 15'b000000100000000,
        S_UPD   = 15'b000001000000000,
        S_RM1   = 15'b000010000000000,
        S_RM2   = 15'b000100000000000,
        S_RCHK  = 15'b001000000000000,
        S_DIV   = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/ara_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module ara_isqrt
    import ara_pkg::*;
#(
    parameter int W = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [W-1:0]         i_radicand,
    output logic                      o_done,
    output logic [(W+1)/2-1:0]        o_root
);
    localparam int STEPS = (W + 1) / 2;

    logic [W-1:0] r_x;
    logic [W-1:0] r_res;
    logic [W-1:0] r_bit;
    logic         r_busy;
    logic         r_done;
    logic [W:0]   trial;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_radicand;
            r_res <= '0;
            r_bit <= W'(1) << (2 * (STEPS - 1));
        end else if (r_busy) begin
            if ({1'b0, r_x} >= trial) begin
                r_x   <= W'({1'b0, r_x} - trial);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[STEPS-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/azimuthal_radial_averager.sv =====
// A load passes through the bit-serial square root and the bin search; a read in a nonzero
// bin adds a 48-step quotient loop unless the quotient saturates.
// One request is in work at a time; a new request is taken when the previous one has left
// the work states, while a finished result may still wait in the output register.
// Reset (synchronous, active low) empties all bins, zeroes both positions and loads the
// default register values; no clearing pass is needed.
`default_nettype none
`include "azimuthal_radial_averager_macros.svh"
module azimuthal_radial_averager
    import ara_pkg::*;
#(
    parameter int GRID     = 128,
    parameter int MAX_BINS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [RAD_W-1:0]    i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_action,
    input  wire logic [PIX_W-1:0]    i_pixel_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [SUM_W-1:0]         o_smoothed_value,
    output logic                     o_in_range,
    output logic                     o_zero_divisor
);
    localparam int RC_W     = $clog2(GRID);
    localparam int DX_W     = RC_W + 2;
    localparam int D2_W     = 2 * RC_W + 2;
    localparam int M1_W     = D2_W + SCALE_W;
    localparam int PROD_W   = D2_W + 2 * SCALE_W;
    localparam int R_W      = (PROD_W + 1) / 2;
    localparam int CMP_W    = ((R_W > RAD_W) ? R_W : RAD_W) + 1;
    localparam int NW       = $clog2(MAX_BINS + 1);
    localparam int NCW      = (NW > NCNT_W) ? NW : NCNT_W;
    localparam int BW       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int XW       = RAD_W + NW;
    localparam int AW       = SUM_W + NW;
    localparam int KW       = TWO_PI_W + BW;
    localparam int DW       = KW + RAD_W;
    localparam int CW       = ((AW > DW) ? AW : DW) + 1;

    // Configuration registers
    logic [RAD_W-1:0]   r_inner;
    logic [RAD_W-1:0]   r_outer;
    logic [NCNT_W-1:0]  r_count;
    logic [SCALE_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= INNER_RST;
            r_outer <= OUTER_RST;
            r_count <= COUNT_RST;
            r_scale <= SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_INNER: r_inner <= i_cfg_data;
                REG_OUTER: r_outer <= i_cfg_data;
                REG_COUNT: r_count <= i_cfg_data[NCNT_W-1:0];
                REG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                default:   r_inner <= r_inner;
            endcase
        end
    end

    logic [NCW-1:0]   n_wide;
    logic [NW-1:0]    eff_n;
    logic [RAD_W-1:0] span;

    assign n_wide = (NCW'(r_count) > NCW'(MAX_BINS)) ? NCW'(MAX_BINS) : NCW'(r_count);
    assign eff_n  = n_wide[NW-1:0];
    assign span   = r_outer - r_inner;

    t_state r_state;
    t_state n_state;

    logic [RC_W-1:0] r_lrow, r_lcol, r_rrow, r_rcol;
    logic             r_is_read;
    logic [PIX_W-1:0] r_pix;
    logic signed [DX_W-1:0] r_dx, r_dy;
    logic [PROD_W-1:0] r_prod;
    logic [R_W-1:0]    r_root;
    logic [XW-1:0]     r_x;
    logic [XW-1:0]     r_dsh;
    logic [BW-1:0]     r_bin;
    logic [CNT_W-1:0]  r_cnt;
    logic [AW-1:0]     r_a;
    logic [DW-1:0]     r_den;
    logic [DW:0]       r_rem;
    logic [SUM_W-1:0]  r_q;
    logic [SUM_W-1:0]  r_res_val;
    logic              r_res_inr;
    logic              r_res_zd;
    logic              r_out_valid;
    logic [SUM_W-1:0]  r_out_val;
    logic              r_out_inr;
    logic              r_out_zd;

    // Bin store with valid bits; an entry not yet written reads as zero.
    logic [SUM_W-1:0]    r_mem [MAX_BINS];
    logic [MAX_BINS-1:0] r_valid;
    logic [SUM_W-1:0]    r_mem_q;
    logic                r_rd_valid;

    logic accept;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Half-pixel offsets of the position that the request addresses
    logic [RC_W-1:0] sel_row, sel_col;
    logic signed [DX_W-1:0] dx_c, dy_c;
    assign sel_row = (t_action'(i_action) == ACT_READ) ? r_rrow : r_lrow;
    assign sel_col = (t_action'(i_action) == ACT_READ) ? r_rcol : r_lcol;
    assign dx_c = $signed({1'b0, sel_row, 1'b0}) - $signed(DX_W'(GRID));
    assign dy_c = $signed({1'b0, sel_col, 1'b0}) - $signed(DX_W'(GRID));

    logic signed [2*DX_W-1:0] dxsq, dysq;
    logic [D2_W-1:0]  d2;
    logic [M1_W-1:0]  m1;
    logic [PROD_W-1:0] m2;
    assign dxsq = r_dx * r_dx;
    assign dysq = r_dy * r_dy;
    assign d2   = dxsq[D2_W-1:0] + dysq[D2_W-1:0];
    assign m1   = r_prod[D2_W-1:0] * r_scale;
    assign m2   = r_prod[M1_W-1:0] * r_scale;

    logic sq_start, sq_done;
    logic [R_W-1:0] sq_root;
    assign sq_start = (r_state == S_SQS);

    ara_isqrt #(.W(PROD_W)) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_prod),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    logic [CMP_W-1:0] r_ext, inner_ext, diff_ext;
    logic             inr;
    logic [XW-1:0]    xprod;
    assign r_ext     = CMP_W'(r_root >> 1);
    assign inner_ext = CMP_W'(r_inner);
    assign diff_ext  = r_ext - inner_ext;
    assign inr = (eff_n != '0) && (r_outer > r_inner) && (r_ext >= inner_ext)
                 && (diff_ext < CMP_W'(span));
    assign xprod = diff_ext[RAD_W-1:0] * eff_n;

    logic [SUM_W-1:0] cur_sum;
    logic [SUM_W:0]   acc;
    logic [SUM_W-1:0] acc_sat;
    logic [AW-1:0]    aprod;
    logic [KW-1:0]    kprod;
    logic [DW-1:0]    dprod;
    logic [DW+1:0]    rem2;
    logic             rem_ge;
    assign cur_sum = r_rd_valid ? r_mem_q : '0;
    assign acc     = {1'b0, cur_sum} + (SUM_W+1)'(r_pix);
    assign acc_sat = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
    assign aprod   = cur_sum * eff_n;
    assign kprod   = TWO_PI_Q16 * r_bin;
    assign dprod   = r_den[KW-1:0] * span;
    assign rem2    = {r_rem, 1'b0};
    assign rem_ge  = rem2 >= (DW+2)'(r_den);

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_action'(i_action) == ACT_LOAD
                               || t_action'(i_action) == ACT_READ)) begin
                    n_state = S_D2;
                end
            end
            S_D2:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_SQS;
            S_SQS:   n_state = S_SQRT;
            S_SQRT:  if (sq_done) n_state = S_RANGE;
            S_RANGE: begin
                if (inr) begin
                    n_state = S_BIN;
                end else if (r_is_read) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BIN:   if (r_cnt == '0) n_state = S_RDMEM;
            S_RDMEM: n_state = S_UPD;
            S_UPD: begin
                if (!r_is_read) begin
                    n_state = S_IDLE;
                end else if (r_bin == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RM1;
                end
            end
            S_RM1:   n_state = S_RM2;
            S_RM2:   n_state = S_RCHK;
            S_RCHK:  n_state = (CW'(r_a) >= CW'(r_den)) ? S_OUT : S_DIV;
            S_DIV:   if (r_cnt == '0) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lrow      <= '0;
            r_lcol      <= '0;
            r_rrow      <= '0;
            r_rcol      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                case (t_action'(i_action))
                    ACT_LOAD: begin
                        if (r_lcol == RC_W'(GRID - 1)) begin
                            r_lcol <= '0;
                            r_lrow <= (r_lrow == RC_W'(GRID - 1)) ? '0 : r_lrow + 1'b1;
                        end else begin
                            r_lcol <= r_lcol + 1'b1;
                        end
                    end
                    ACT_READ: begin
                        if (r_rcol == RC_W'(GRID - 1)) begin
                            r_rcol <= '0;
                            r_rrow <= (r_rrow == RC_W'(GRID - 1)) ? '0 : r_rrow + 1'b1;
                        end else begin
                            r_rcol <= r_rcol + 1'b1;
                        end
                    end
                    ACT_CLEAR: begin
                        r_lrow  <= '0;
                        r_lcol  <= '0;
                        r_rrow  <= '0;
                        r_rcol  <= '0;
                        r_valid <= '0;
                    end
                    default: r_valid <= r_valid;
                endcase
            end
            if (r_state == S_UPD && !r_is_read) begin
                r_valid[r_bin] <= 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD && !r_is_read) begin
            r_mem[r_bin] <= acc_sat;
        end
        r_mem_q    <= r_mem[r_bin];
        r_rd_valid <= r_valid[r_bin];
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_read <= (t_action'(i_action) == ACT_READ);
            r_pix     <= i_pixel_value;
            r_dx      <= dx_c;
            r_dy      <= dy_c;
        end
        case (r_state)
            S_D2: r_prod <= PROD_W'(d2);
            S_M1: r_prod <= PROD_W'(m1);
            S_M2: r_prod <= m2;
            S_SQRT: if (sq_done) r_root <= sq_root;
            S_RANGE: begin
                r_x   <= xprod;
                r_dsh <= XW'(span) << (BW - 1);
                r_bin <= '0;
                r_cnt <= CNT_W'(BW - 1);
                r_res_val <= '0;
                r_res_inr <= 1'b0;
                r_res_zd  <= 1'b0;
            end
            S_BIN: begin
                if (r_x >= r_dsh) begin
                    r_x   <= r_x - r_dsh;
                    r_bin <= BW'({r_bin, 1'b1});
                end else begin
                    r_bin <= BW'({r_bin, 1'b0});
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            S_UPD: begin
                r_a       <= aprod;
                r_den     <= DW'(kprod);
                r_res_val <= SUM_MAX;
                r_res_inr <= 1'b1;
                r_res_zd  <= (r_bin == '0);
            end
            S_RM2: r_den <= dprod;
            S_RCHK: begin
                r_rem <= (DW+1)'(r_a);
                r_q   <= '0;
                r_cnt <= CNT_W'(SUM_W - 1);
            end
            S_DIV: begin
                if (rem_ge) begin
                    r_rem <= (DW+1)'(rem2 - (DW+2)'(r_den));
                end else begin
                    r_rem <= rem2[DW:0];
                end
                r_q   <= {r_q[SUM_W-2:0], rem_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_res_val <= {r_q[SUM_W-2:0], rem_ge};
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_val <= r_res_val;
            r_out_inr <= r_res_inr;
            r_out_zd  <= r_res_zd;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_smoothed_value = r_out_val;
    assign o_in_range       = r_out_inr;
    assign o_zero_divisor   = r_out_zd;

    `ARA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        r_state == S_OUT && r_out_valid && !i_out_ready, r_state == S_OUT)
    `ARA_ASSERT_NOW(a_zd_sat, i_clk, i_rst_n,
        o_out_valid && o_zero_divisor, o_in_range && o_smoothed_value == SUM_MAX)
    `ARA_ASSERT_NOW(a_out_zero, i_clk, i_rst_n,
        o_out_valid && !o_in_range, o_smoothed_value == '0 && !o_zero_divisor)
    `ARA_ASSERT_NEXT(a_clear, i_clk, i_rst_n,
        accept && t_action'(i_action) == ACT_CLEAR, r_valid == '0)

endmodule
`default_nettype wire

// ===== bench/tb_azimuthal_radial_averager.sv =====
// Self-checking testbench for the azimuthal radial averager with a built-in predictor.
`default_nettype none
module tb_azimuthal_radial_averager;
    import ara_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID      = 128;
    localparam int NBINS     = 16;
    localparam int NPIX      = GRID * GRID;
    localparam int SETTLE    = 200;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        t_action         action;
        logic [PIX_W-1:0] pixel;
    } t_request;

    typedef struct packed {
        logic [SUM_W-1:0] value;
        logic             in_range;
        logic             zero_div;
    } t_smoothed;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [RAD_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_action;
    logic [PIX_W-1:0]    i_pixel_value;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [SUM_W-1:0]    o_smoothed_value;
    logic                o_in_range;
    logic                o_zero_divisor;

    azimuthal_radial_averager #(.GRID(GRID), .MAX_BINS(NBINS)) DUT (.*);

    // Predictor state.
    logic [SUM_W-1:0]   bin_sum [NBINS];
    int unsigned        load_pos;
    int unsigned        read_pos;
    logic [RAD_W-1:0]   inner_q;
    logic [RAD_W-1:0]   outer_q;
    logic [NCNT_W-1:0]  count_q;
    logic [SCALE_W-1:0] scale_q;

    t_request  pending_requests[$];
    t_smoothed expected_smoothed[$];
    t_request  cur_req;
    int        errors;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        wdog;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic int unsigned eff_count();
        return (count_q > NBINS) ? NBINS : count_q;
    endfunction

    function automatic logic find_bin(input int unsigned pos, output int unsigned bin);
        longint      dx;
        longint      dy;
        logic [63:0] d2;
        logic [63:0] r;
        logic [63:0] span;
        logic [63:0] diff;
        int unsigned n;
        dx   = 2 * longint'(pos / GRID) - GRID;
        dy   = 2 * longint'(pos % GRID) - GRID;
        d2   = dx * dx + dy * dy;
        r    = isqrt(d2 * scale_q * scale_q) >> 1;
        n    = eff_count();
        bin  = 0;
        if (n == 0 || outer_q <= inner_q || r < inner_q) return 1'b0;
        span = outer_q - inner_q;
        diff = r - inner_q;
        if (diff >= span) return 1'b0;
        bin = int'(diff * n / span);
        return 1'b1;
    endfunction

    function automatic int unsigned next_pos(input int unsigned p);
        return (p + 1 >= NPIX) ? 0 : p + 1;
    endfunction

    // Applies one accepted request to the predictor; reads queue their expected result.
    function automatic void predict_request(input t_request req);
        int unsigned  bin;
        logic [63:0]  s;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        t_smoothed    res;
        case (req.action)
            ACT_LOAD: begin
                if (find_bin(load_pos, bin)) begin
                    s = bin_sum[bin] + req.pixel;
                    bin_sum[bin] = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
                end
                load_pos = next_pos(load_pos);
            end
            ACT_READ: begin
                res = '0;
                if (find_bin(read_pos, bin)) begin
                    res.in_range = 1'b1;
                    if (bin == 0) begin
                        res.value    = SUM_MAX;
                        res.zero_div = 1'b1;
                    end else begin
                        num = (128'(bin_sum[bin]) * eff_count()) << 48;
                        den = 128'(TWO_PI_Q16) * bin * (outer_q - inner_q);
                        q   = num / den;
                        res.value = (q > SUM_MAX) ? SUM_MAX : q[SUM_W-1:0];
                    end
                end
                read_pos = next_pos(read_pos);
                expected_smoothed.push_back(res);
            end
            ACT_CLEAR: begin
                for (int k = 0; k < NBINS; k++) bin_sum[k] = '0;
                load_pos = 0;
                read_pos = 0;
            end
            default: ;
        endcase
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_request(cur_req);
            if (!i_in_valid || o_in_ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_requests.pop_front();
                    i_in_valid    <= 1'b1;
                    i_action      <= cur_req.action;
                    i_pixel_value <= cur_req.pixel;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_smoothed exp_v;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_smoothed.size() == 0) begin
                    $display("%0t: unexpected result value=%h in_range=%b zero_div=%b",
                             $time, o_smoothed_value, o_in_range, o_zero_divisor);
                    errors++;
                end else begin
                    exp_v = expected_smoothed.pop_front();
                    if (o_smoothed_value !== exp_v.value) begin
                        $display("%0t: smoothed_value expected %h actual %h",
                                 $time, exp_v.value, o_smoothed_value);
                        errors++;
                    end
                    if (o_in_range !== exp_v.in_range) begin
                        $display("%0t: in_range expected %b actual %b",
                                 $time, exp_v.in_range, o_in_range);
                        errors++;
                    end
                    if (o_zero_divisor !== exp_v.zero_div) begin
                        $display("%0t: zero_divisor expected %b actual %b",
                                 $time, exp_v.zero_div, o_zero_divisor);
                        errors++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("azimuthal_radial_averager: mismatch");
                $finish;
            end
        end
    end

    task automatic write_reg(input t_reg_index idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= RAD_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_INNER: inner_q = RAD_W'(val);
            REG_OUTER: outer_q = RAD_W'(val);
            REG_COUNT: count_q = NCNT_W'(val);
            default:   scale_q = SCALE_W'(val);
        endcase
    endtask

    task automatic wait_idle();
        while (pending_requests.size() > 0 || i_in_valid || expected_smoothed.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_req(input t_action a, input logic [PIX_W-1:0] p);
        t_request r;
        r.action = a;
        r.pixel  = p;
        pending_requests.push_back(r);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Picks a random scale, annulus and bin count; modes 0, 1 and 2 force a full, an empty and a random geometry.
    task automatic configure(input int mode);
        int unsigned s;
        int unsigned inn;
        int unsigned out_r;
        s     = $urandom_range(1, 16000);
        inn   = $urandom_range(0, 64 * s);
        out_r = inn + $urandom_range(1, 40 * s);
        case (mode)
            0: begin inn = 0; out_r = 20'hFFFFF; s = 16'hFFFF; end
            1: begin inn = 20'hFFFFF; out_r = 0; end
            2: begin inn = $urandom; out_r = $urandom; s = $urandom; end
            default: ;
        endcase
        if (out_r > 20'hFFFFF) out_r = 20'hFFFFF;
        write_reg(REG_SCALE, s);
        write_reg(REG_INNER, inn);
        write_reg(REG_OUTER, out_r);
        case ($urandom_range(3))
            0:       write_reg(REG_COUNT, 16);
            1:       write_reg(REG_COUNT, $urandom_range(0, 31));
            default: write_reg(REG_COUNT, $urandom_range(1, 16));
        endcase
    endtask

    initial begin
        int n;
        errors        = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_action      = ACT_NONE;
        i_pixel_value = '0;
        i_out_ready   = 1'b0;
        for (int k = 0; k < NBINS; k++) bin_sum[k] = '0;
        load_pos = 0;
        read_pos = 0;
        inner_q  = INNER_RST;
        outer_q  = OUTER_RST;
        count_q  = COUNT_RST;
        scale_q  = SCALE_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: each request kind at reset defaults, then a geometry with the first row in bins.
        push_req(ACT_READ, '0);
        push_req(ACT_NONE, '1);
        push_req(ACT_LOAD, '1);
        push_req(ACT_CLEAR, '0);
        wait_idle();
        write_reg(REG_SCALE, 1000);
        write_reg(REG_INNER, 64000);
        write_reg(REG_OUTER, 91000);
        write_reg(REG_COUNT, 16);
        for (int k = 0; k < 8; k++) push_req(ACT_LOAD, (k % 2) ? '1 : '0);
        for (int k = 0; k < 8; k++) push_req(ACT_READ, '0);
        push_req(ACT_NONE, 32'h5A5A5A5A);
        push_req(ACT_CLEAR, '0);
        push_req(ACT_READ, '0);
        wait_idle();
        write_reg(REG_COUNT, 0);
        push_req(ACT_LOAD, '1);
        push_req(ACT_READ, '0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            configure((ph < 3) ? ph : 3);
            push_req(ACT_CLEAR, '0);
            n = $urandom_range(50, 90);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(19) == 0) push_req(ACT_NONE, $urandom);
                else push_req(ACT_LOAD, rand_pixel());
            end
            // In phase 2, wait until the block has drained before queuing the mixed requests.
            if (ph == 2) while (pending_requests.size() > 0 || i_in_valid ||
                                expected_smoothed.size() > 0) @(posedge i_clk);
            n = $urandom_range(40, 80);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(39))
                    0:       push_req(ACT_CLEAR, $urandom);
                    1, 2:    push_req(ACT_LOAD, rand_pixel());
                    3:       push_req(ACT_NONE, $urandom);
                    default: push_req(ACT_READ, $urandom);
                endcase
            end
            wait_idle();
        end

        if (errors == 0 && expected_smoothed.size() == 0) begin
            $display("azimuthal_radial_averager: match");
        end else begin
            $display("azimuthal_radial_averager: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ara_pkg.sv
hw/rtl/ara_isqrt.sv
hw/rtl/azimuthal_radial_averager.sv
bench/tb_azimuthal_radial_averager.sv
